[rtl/srb_pkg.sv]
package srb_pkg;

   // Field widths
   localparam int SEQ_W = 10;
   localparam int TAG_W = 16;

   // First sequence number past the valid range
   localparam logic [SEQ_W-1:0] SEQ_LIMIT = 10'd1000;

   // Default depth of the early-arrival store
   localparam int DEFAULT_SLOTS = 16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_LOOKUP,
      ST_PRESENT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the incoming transaction
      logic key_next;  // match the store against expected_last + 1
      logic load_in;   // deliver the captured item, advance expected_last
      logic store;     // write the captured item into the lowest free slot
      logic lookup;    // record whether the next number sits in the store
      logic drain;     // move the found slot to the output, free it
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic in_order;  // captured item is the next one in order
      logic store_ok;  // captured item is early, new, and a slot is free
      logic hit;       // recorded lookup found the next number
   } status_type;

endpackage

[rtl/sequence_reorder_buffer.sv]
// Receive reorder buffer for sequence numbers 1 to 999. A request carrying
// the next number after the last delivered one is delivered, then every held
// early arrival that continues the run is delivered after it, one response
// each; last_of_run marks the final response caused by a request. Early
// numbers go into the lowest free of SLOTS slots; old, out-of-range, duplicate
// or overflowing requests are dropped with no response. A request that is
// dropped or stored passes through accept and classify only. A delivering
// request passes through accept and classify, then each response needs a
// lookup step, where the parallel slot match against the next number runs,
// and a presenting step, which response back-pressure can stall. Numbers do
// not wrap: after 999 every request is dropped until reset.
module sequence_reorder_buffer #(
   parameter int SLOTS = srb_pkg::DEFAULT_SLOTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [srb_pkg::SEQ_W-1:0] req_seq_number,
   input  logic [srb_pkg::TAG_W-1:0] req_payload_tag,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [srb_pkg::SEQ_W-1:0] rsp_delivered_seq,
   output logic [srb_pkg::TAG_W-1:0] rsp_delivered_tag,
   output logic                      rsp_last_of_run
);

   srb_pkg::cmd_type    cmd;
   srb_pkg::status_type status;

   // Sequence the classify, lookup and drain steps
   srb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the store, the last delivered number and the output register
   srb_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_seq_number    (req_seq_number),
      .req_payload_tag   (req_payload_tag),
      .rsp_delivered_seq (rsp_delivered_seq),
      .rsp_delivered_tag (rsp_delivered_tag),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

[rtl/srb_ctrl.sv]
module srb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  srb_pkg::status_type  status,
   output srb_pkg::cmd_type     cmd
);

   srb_pkg::state_type state_ff;
   srb_pkg::state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srb_pkg::ST_IDLE: begin
            if (req_valid) state_in = srb_pkg::ST_CLASSIFY;
         end
         srb_pkg::ST_CLASSIFY: begin
            if (status.in_order) state_in = srb_pkg::ST_LOOKUP;
            else                 state_in = srb_pkg::ST_IDLE;
         end
         srb_pkg::ST_LOOKUP: begin
            state_in = srb_pkg::ST_PRESENT;
         end
         srb_pkg::ST_PRESENT: begin
            if (rsp_ready) begin
               if (status.hit) state_in = srb_pkg::ST_LOOKUP;
               else            state_in = srb_pkg::ST_IDLE;
            end
         end
         default: state_in = srb_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath commands; refuse transactions while in reset
   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         srb_pkg::ST_IDLE: begin
            req_ready   = !reset;
            cmd.capture = req_valid && !reset;
         end
         srb_pkg::ST_CLASSIFY: begin
            cmd.load_in = status.in_order;
            cmd.store   = !status.in_order && status.store_ok;
         end
         srb_pkg::ST_LOOKUP: begin
            cmd.key_next = 1'b1;
            cmd.lookup   = 1'b1;
         end
         srb_pkg::ST_PRESENT: begin
            rsp_valid = 1'b1;
            cmd.drain = rsp_ready && status.hit;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Every lookup is followed by a presented result
   a_lookup_presents: assert property (@(posedge clock) disable iff (reset)
      state_ff == srb_pkg::ST_LOOKUP |=> state_ff == srb_pkg::ST_PRESENT)
      else $error("lookup not followed by a result");

   // A taken final result returns to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !status.hit) |=> req_ready)
      else $error("final result did not return to idle");

   // Store and deliver never fire together
   a_store_xor_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.store && cmd.load_in))
      else $error("store and deliver issued together");

endmodule

[rtl/srb_datapath.sv]
module srb_datapath #(
   parameter int SLOTS = srb_pkg::DEFAULT_SLOTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  srb_pkg::cmd_type          cmd,
   output srb_pkg::status_type       status,
   input  logic [srb_pkg::SEQ_W-1:0] req_seq_number,
   input  logic [srb_pkg::TAG_W-1:0] req_payload_tag,
   output logic [srb_pkg::SEQ_W-1:0] rsp_delivered_seq,
   output logic [srb_pkg::TAG_W-1:0] rsp_delivered_tag,
   output logic                      rsp_last_of_run
);

   localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [srb_pkg::SEQ_W-1:0] cap_seq_ff;
   logic [srb_pkg::TAG_W-1:0] cap_tag_ff;
   logic [srb_pkg::SEQ_W-1:0] expected_last_ff;
   logic [srb_pkg::SEQ_W-1:0] expected_last_in;
   logic [SLOTS-1:0]          slot_valid_ff;
   logic [SLOTS-1:0]          slot_valid_in;
   logic [srb_pkg::SEQ_W-1:0] slot_seq_ff [SLOTS];
   logic [srb_pkg::TAG_W-1:0] slot_tag_ff [SLOTS];
   logic [srb_pkg::SEQ_W-1:0] out_seq_ff;
   logic [srb_pkg::TAG_W-1:0] out_tag_ff;
   logic                      out_last_ff;
   logic                      hit_ff;
   logic [IdxW-1:0]           hit_idx_ff;

   logic [srb_pkg::SEQ_W-1:0] next_seq;
   logic [srb_pkg::SEQ_W-1:0] match_key;
   logic [SLOTS-1:0]          match_vec;
   logic                      match_any;
   logic [IdxW-1:0]           match_idx;
   logic                      free_any;
   logic [IdxW-1:0]           free_idx;
   logic                      hit_now;

   assign next_seq  = expected_last_ff + 1'b1;
   assign match_key = cmd.key_next ? next_seq : cap_seq_ff;

   // Compare every slot against the key in parallel
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_vec[i] = slot_valid_ff[i] && (slot_seq_ff[i] == match_key);
      end
   end

   assign match_any = |match_vec;
   assign free_any  = !(&slot_valid_ff);

   // Pick the lowest matching slot and the lowest free slot
   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match_vec[i])      match_idx = IdxW'(i);
         if (!slot_valid_ff[i]) free_idx  = IdxW'(i);
      end
   end

   assign hit_now = match_any && (next_seq < srb_pkg::SEQ_LIMIT);

   // Classify the captured transaction
   always_comb begin
      status.in_order = (cap_seq_ff == next_seq) && (cap_seq_ff < srb_pkg::SEQ_LIMIT);
      status.store_ok = (cap_seq_ff < srb_pkg::SEQ_LIMIT)
                        && (cap_seq_ff > expected_last_ff)
                        && !match_any && free_any;
      status.hit      = hit_ff;
   end

   // Capture the incoming transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_seq_ff <= req_seq_number;
         cap_tag_ff <= req_payload_tag;
      end
   end

   // Advance the last delivered number and the slot valid bits
   always_comb begin
      expected_last_in = expected_last_ff;
      slot_valid_in    = slot_valid_ff;
      if (cmd.load_in) expected_last_in = cap_seq_ff;
      if (cmd.drain) begin
         expected_last_in         = next_seq;
         slot_valid_in[hit_idx_ff] = 1'b0;
      end
      if (cmd.store) slot_valid_in[free_idx] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_last_ff <= '0;
         slot_valid_ff    <= '0;
         hit_ff           <= 1'b0;
      end else begin
         expected_last_ff <= expected_last_in;
         slot_valid_ff    <= slot_valid_in;
         if (cmd.lookup) hit_ff <= hit_now;
      end
   end

   // Write slot contents
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         slot_seq_ff[free_idx] <= cap_seq_ff;
         slot_tag_ff[free_idx] <= cap_tag_ff;
      end
   end

   // Load the output register and record the lookup result
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         out_seq_ff <= cap_seq_ff;
         out_tag_ff <= cap_tag_ff;
      end else if (cmd.drain) begin
         out_seq_ff <= slot_seq_ff[hit_idx_ff];
         out_tag_ff <= slot_tag_ff[hit_idx_ff];
      end
      if (cmd.lookup) begin
         out_last_ff <= !hit_now;
         hit_idx_ff  <= match_idx;
      end
   end

   assign rsp_delivered_seq = out_seq_ff;
   assign rsp_delivered_tag = out_tag_ff;
   assign rsp_last_of_run   = out_last_ff;

   // The last delivered number never leaves the valid range
   a_expected_range: assert property (@(posedge clock) disable iff (reset)
      expected_last_ff < srb_pkg::SEQ_LIMIT)
      else $error("expected_last out of range");

   // A drain advances the last delivered number by one
   a_drain_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.drain |=> expected_last_ff == $past(expected_last_ff) + 1'b1)
      else $error("drain did not advance expected_last");

   // A store fills exactly one more slot
   a_store_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.store |=> $countones(slot_valid_ff) == $past($countones(slot_valid_ff)) + 1)
      else $error("store did not fill one slot");

endmodule

[tb/sequence_reorder_buffer_test.sv]
module sequence_reorder_buffer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import srb_pkg::*;

   localparam int HELD_SLOTS  = DEFAULT_SLOTS;
   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 12;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic [TAG_W-1:0] tag;
      logic             last;
   } delivery_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [SEQ_W-1:0] req_seq_number = '0;
   logic [TAG_W-1:0] req_payload_tag = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [SEQ_W-1:0] rsp_delivered_seq;
   logic [TAG_W-1:0] rsp_delivered_tag;
   logic             rsp_last_of_run;

   // Shadow of the reorder state
   logic [SEQ_W-1:0] last_delivered;
   logic             held_valid [HELD_SLOTS];
   logic [SEQ_W-1:0] held_seq [HELD_SLOTS];
   logic [TAG_W-1:0] held_tag [HELD_SLOTS];

   delivery_type expected_deliveries[$];
   delivery_type arrived;
   int           mismatch_count = 0;
   int           stall_cycles = 0;
   int           send_idle_pct = 0;
   int           rsp_idle_pct = 0;

   sequence_reorder_buffer u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_seq_number    (req_seq_number),
      .req_payload_tag   (req_payload_tag),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_delivered_seq (rsp_delivered_seq),
      .rsp_delivered_tag (rsp_delivered_tag),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always #6 clock = ~clock;

   // Return the slot holding seq, or -1 when no valid slot has it
   function automatic int find_held(input logic [SEQ_W-1:0] seq);
      int i;
      for (i = 0; i < HELD_SLOTS; i++) begin
         if (held_valid[i] && held_seq[i] == seq) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Advance the shadow state for one arrival and queue the deliveries it causes.
   // Returns 1 when the arrival was stored or delivered, 0 when dropped.
   function automatic bit predict_arrival(input logic [SEQ_W-1:0] seq,
                                          input logic [TAG_W-1:0] tag);
      int           i;
      int           hit;
      delivery_type cur;
      if (seq >= SEQ_LIMIT || seq <= last_delivered) begin
         return 1'b0;
      end
      // Early arrival: hold it unless it is a duplicate or the store is full
      if (seq != last_delivered + 1) begin
         if (find_held(seq) >= 0) begin
            return 1'b0;
         end
         for (i = 0; i < HELD_SLOTS; i++) begin
            if (!held_valid[i]) begin
               held_valid[i] = 1'b1;
               held_seq[i]   = seq;
               held_tag[i]   = tag;
               return 1'b1;
            end
         end
         return 1'b0;
      end
      // In order: deliver it, then drain every held item that continues the run
      cur.seq  = seq;
      cur.tag  = tag;
      cur.last = 1'b0;
      last_delivered = seq;
      forever begin
         if (int'(last_delivered) + 1 >= int'(SEQ_LIMIT)) begin
            break;
         end
         hit = find_held(last_delivered + 1'b1);
         if (hit < 0) begin
            break;
         end
         expected_deliveries.push_back(cur);
         cur.seq  = held_seq[hit];
         cur.tag  = held_tag[hit];
         held_valid[hit] = 1'b0;
         last_delivered  = last_delivered + 1'b1;
      end
      cur.last = 1'b1;
      expected_deliveries.push_back(cur);
      return 1'b1;
   endfunction

   function automatic void report_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
         $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
      end
   endfunction

   // Offer one transaction and hold it until accepted; valid stays high afterward
   task automatic send_item(input logic [SEQ_W-1:0] seq, input logic [TAG_W-1:0] tag,
                            output bit taken);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_seq_number  <= seq;
      req_payload_tag <= tag;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      taken = predict_arrival(seq, tag);
   endtask

   task automatic send_fixed(input int seq, input int tag);
      bit taken;
      send_item(SEQ_W'(seq), TAG_W'(tag), taken);
   endtask

   task automatic set_idling(input int send_pct, input int rsp_pct);
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
   endtask

   // Old, zero and out-of-range numbers, the first in-order delivery, then a repeat
   task automatic test_dropped_items();
      send_fixed(0, 16'h0000);
      send_fixed(1000, 16'h1234);
      send_fixed(1023, 16'hFFFF);
      send_fixed(1, 16'hFFFF);
      send_fixed(1, 16'h0000);
   endtask

   // Fill every slot with early items, overflow it, repeat one, then release the run
   task automatic test_full_store_drain();
      int base;
      int i;
      base = int'(last_delivered);
      for (i = 2; i <= HELD_SLOTS + 1; i++) begin
         send_fixed(base + i, (i == 2) ? 16'hFFFF : $urandom_range(16'hFFFF));
      end
      send_fixed(base + HELD_SLOTS + 2, $urandom_range(16'hFFFF));
      send_fixed(base + 5, 16'h0000);
      send_fixed(base + 1, $urandom_range(16'hFFFF));
   endtask

   // Mostly shuffled in-order windows, with old, far-early, duplicate and junk noise
   task automatic test_random_windows(input int useful_target);
      logic [SEQ_W-1:0] batch [16];
      logic [SEQ_W-1:0] tmp;
      int               useful;
      int               len;
      int               base;
      int               i;
      int               j;
      int               pick;
      int               seq;
      bit               taken;
      useful = 0;
      while (useful < useful_target) begin
         if ($urandom_range(99) < 80) begin
            base = int'(last_delivered) + 1;
            len  = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            if (base + len - 1 > 999) begin
               len = 1000 - base;
            end
            for (i = 0; i < len; i++) begin
               batch[i] = SEQ_W'(base + i);
            end
            for (i = len - 1; i > 0; i--) begin
               j        = $urandom_range(i);
               tmp      = batch[i];
               batch[i] = batch[j];
               batch[j] = tmp;
            end
            for (i = 0; i < len; i++) begin
               send_item(batch[i], TAG_W'($urandom_range(16'hFFFF)), taken);
               if (taken) begin
                  useful++;
               end
            end
         end else begin
            case ($urandom_range(4))
               0: seq = $urandom_range(int'(last_delivered));
               1: seq = int'(last_delivered) + $urandom_range(2, 40);
               2: seq = $urandom_range(1000, 1023);
               3: seq = $urandom_range(1023);
               default: begin
                  // repeat a held number when there is one
                  seq  = $urandom_range(int'(last_delivered));
                  pick = $urandom_range(HELD_SLOTS - 1);
                  for (i = 0; i < HELD_SLOTS; i++) begin
                     if (held_valid[(pick + i) % HELD_SLOTS]) begin
                        seq = held_seq[(pick + i) % HELD_SLOTS];
                        break;
                     end
                  end
               end
            endcase
            send_item(SEQ_W'(seq), TAG_W'($urandom_range(16'hFFFF)), taken);
            if (taken) begin
               useful++;
            end
         end
      end
   endtask

   // Junk and old numbers late in the run, then the next number to flush the store
   task automatic test_late_drops();
      send_fixed(1023, $urandom_range(16'hFFFF));
      send_fixed(1000, 16'h0000);
      send_fixed(int'(last_delivered), 16'hFFFF);
      send_fixed(int'(last_delivered) + 1, $urandom_range(16'hFFFF));
   endtask

   initial begin
      int i;
      last_delivered = '0;
      for (i = 0; i < HELD_SLOTS; i++) begin
         held_valid[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_idling(18, 81);
      test_dropped_items();
      test_full_store_drain();
      test_random_windows(50);
      set_idling(81, 18);
      test_random_windows(50);
      set_idling(0, 0);
      test_random_windows(50);
      test_late_drops();
      req_valid <= 1'b0;

      // Wait out the remaining deliveries, then give stray results time to show
      while (expected_deliveries.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_deliveries.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Toggle result back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Check each delivered transaction against the oldest pending one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_deliveries.size() == 0) begin
            report_mismatch("delivery with nothing pending, seq", 0,
                            int'(rsp_delivered_seq));
         end else begin
            arrived = expected_deliveries.pop_front();
            if (rsp_delivered_seq !== arrived.seq) begin
               report_mismatch("delivered_seq", int'(arrived.seq), int'(rsp_delivered_seq));
            end
            if (rsp_delivered_tag !== arrived.tag) begin
               report_mismatch("delivered_tag", int'(arrived.tag), int'(rsp_delivered_tag));
            end
            if (rsp_last_of_run !== arrived.last) begin
               report_mismatch("last_of_run", int'(arrived.last), int'(rsp_last_of_run));
            end
         end
      end
   end

   // Stop the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

endmodule
